>>> rtl/core/ctec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cook timer entry controller package
// Shared types, codes and constants for the cook timer entry controller.
// ----------------------------------------------------------------------------
package ctec_pkg;

    localparam int SECS_W  = 12;
    localparam int RATE_W  = 8;
    localparam int KEY_W   = 8;
    localparam int DIGIT_W = 4;
    localparam int NDIGITS = 4;
    localparam int COUNT_W = 3;
    localparam int TOTAL_W = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_WEIGHT = 3'd1,
        MODE_TIME   = 3'd2,
        MODE_RUN    = 3'd3,
        MODE_PAUSE  = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_OK        = 3'd1,
        EV_ENTRY_ERR = 3'd2,
        EV_MAX_ERR   = 3'd3,
        EV_INPUT_ERR = 3'd4,
        EV_DONE      = 3'd5,
        EV_STOPPED   = 3'd6
    } t_event;

    typedef enum logic [1:0] {
        OP_KEY   = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEF    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHICKEN = 2'd2;

    localparam logic [SECS_W-1:0] PRESET_RESET  = 12'd60;
    localparam logic [RATE_W-1:0] BEEF_RESET    = 8'd30;
    localparam logic [RATE_W-1:0] CHICKEN_RESET = 8'd12;

    localparam logic [KEY_W-1:0] KEY_A     = 8'h41;
    localparam logic [KEY_W-1:0] KEY_B     = 8'h42;
    localparam logic [KEY_W-1:0] KEY_C     = 8'h43;
    localparam logic [KEY_W-1:0] KEY_D     = 8'h44;
    localparam logic [KEY_W-1:0] KEY_ENTER = 8'h45;
    localparam logic [KEY_W-1:0] KEY_0     = 8'h30;
    localparam logic [KEY_W-1:0] KEY_1     = 8'h31;
    localparam logic [KEY_W-1:0] KEY_9     = 8'h39;

    localparam logic [DIGIT_W-1:0] MAX_MIN_TENS = 4'd3;
    localparam logic [DIGIT_W-1:0] MAX_SEC_TENS = 4'd5;
    localparam logic [COUNT_W-1:0] FULL_COUNT   = 3'd4;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key_code;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        mode;
        logic [SECS_W-1:0] remaining_seconds;
        logic [15:0]       entered_digits;
        logic              lamp_on;
        logic [2:0]        event_res;
    } t_out_item;

endpackage
`default_nettype wire

>>> rtl/core/cook_timer_entry_controller_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cook timer entry controller
// Preset, weight and MM:SS entry with a run/pause/cancel countdown timer.
// ----------------------------------------------------------------------------
// Path: an input item is held in the input register, then its result in the
// result register; the whole step is one pass of logic.
// Throughput: one item per cycle while the result register is not stalled.
// Reset (i_rst_n low, synchronous): idle, digits cleared, registers at
// their defaults, both pipeline registers empty.
module cook_timer_entry_controller_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire ctec_pkg::t_in_item         i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output ctec_pkg::t_out_item             o_out_data,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [ctec_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ctec_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ctec_pkg::*;

    logic [SECS_W-1:0]  r_preset;
    logic [RATE_W-1:0]  r_beef;
    logic [RATE_W-1:0]  r_chicken;

    logic               r_in_vld;
    t_in_item           r_in;
    logic               r_out_vld;
    t_out_item          r_out;

    t_mode              r_mode,    n_mode;
    logic               r_chick,   n_chick;
    logic [DIGIT_W-1:0] r_digit [NDIGITS];
    logic [DIGIT_W-1:0] n_digit [NDIGITS];
    logic [COUNT_W-1:0] r_count,   n_count;
    logic [SECS_W-1:0]  r_secs,    n_secs;
    t_event             w_event;
    t_out_item          w_res;

    logic               w_fire;
    logic               w_is_digit;
    logic [DIGIT_W-1:0] w_key_val;
    logic [TOTAL_W-1:0] w_total;
    logic [SECS_W-1:0]  w_weight_secs;
    logic [RATE_W-1:0]  w_rate;
    logic               w_over_max;

    assign w_fire      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || w_fire;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign w_is_digit    = (r_in.key_code >= KEY_0) && (r_in.key_code <= KEY_9);
    assign w_key_val     = r_in.key_code[DIGIT_W-1:0];
    assign w_total       = TOTAL_W'(r_digit[0]) * TOTAL_W'(600)
                         + TOTAL_W'(r_digit[1]) * TOTAL_W'(60)
                         + TOTAL_W'(r_digit[2]) * TOTAL_W'(10)
                         + TOTAL_W'(r_digit[3]);
    assign w_rate        = r_chick ? r_chicken : r_beef;
    assign w_weight_secs = SECS_W'(w_key_val) * SECS_W'(w_rate);
    assign w_over_max    = (r_digit[1] > MAX_MIN_TENS)
                         || ((r_digit[1] == MAX_MIN_TENS)
                             && ((r_digit[2] | r_digit[3] | w_key_val) != '0));

    // Next state and event for the item in the input register.
    always_comb begin
        logic do_start;
        do_start = 1'b0;
        n_mode   = r_mode;
        n_chick  = r_chick;
        n_digit  = r_digit;
        n_count  = r_count;
        n_secs   = r_secs;
        w_event  = EV_NONE;
        case (r_mode)
            MODE_IDLE: begin
                if (r_in.op == OP_KEY) begin
                    if (r_in.key_code == KEY_A) begin
                        n_secs = r_preset;
                        if (r_preset == '0) begin
                            w_event = EV_DONE;
                        end else begin
                            n_mode  = MODE_RUN;
                            w_event = EV_OK;
                        end
                    end else if (r_in.key_code == KEY_B || r_in.key_code == KEY_C) begin
                        n_chick = (r_in.key_code == KEY_C);
                        n_mode  = MODE_WEIGHT;
                        w_event = EV_OK;
                    end else if (r_in.key_code == KEY_D) begin
                        n_digit = '{default: '0};
                        n_count = '0;
                        n_mode  = MODE_TIME;
                        w_event = EV_OK;
                    end
                end
            end
            MODE_WEIGHT: begin
                if (r_in.op == OP_KEY) begin
                    if (r_in.key_code >= KEY_1 && r_in.key_code <= KEY_9) begin
                        n_secs = w_weight_secs;
                        if (w_weight_secs == '0) begin
                            n_mode  = MODE_IDLE;
                            w_event = EV_DONE;
                        end else begin
                            n_mode  = MODE_RUN;
                            w_event = EV_OK;
                        end
                    end else begin
                        w_event = EV_ENTRY_ERR;
                    end
                end
            end
            MODE_TIME: begin
                if (r_in.op == OP_KEY) begin
                    if (r_in.key_code == KEY_ENTER) begin
                        do_start = 1'b1;
                    end else if (r_count >= FULL_COUNT) begin
                        w_event = EV_NONE;
                    end else if (!w_is_digit) begin
                        n_digit = '{default: '0};
                        n_count = '0;
                        w_event = EV_ENTRY_ERR;
                    end else if (w_over_max) begin
                        n_digit = '{default: '0};
                        n_count = '0;
                        w_event = EV_MAX_ERR;
                    end else begin
                        n_digit = '{r_digit[1], r_digit[2], r_digit[3], w_key_val};
                        n_count = r_count + COUNT_W'(1);
                        w_event = EV_OK;
                    end
                end else if (r_in.op == OP_START) begin
                    do_start = 1'b1;
                end else if (r_in.op == OP_STOP) begin
                    n_digit = '{default: '0};
                    n_count = '0;
                end
                if (do_start) begin
                    if (r_digit[2] > MAX_SEC_TENS) begin
                        n_digit = '{default: '0};
                        n_count = '0;
                        w_event = EV_INPUT_ERR;
                    end else begin
                        n_secs = w_total[SECS_W-1:0];
                        if (w_total[SECS_W-1:0] == '0) begin
                            n_mode  = MODE_IDLE;
                            w_event = EV_DONE;
                        end else begin
                            n_mode  = MODE_RUN;
                            w_event = EV_OK;
                        end
                    end
                end
            end
            MODE_RUN: begin
                if (r_in.op == OP_TICK) begin
                    if (r_secs <= SECS_W'(1)) begin
                        n_secs  = '0;
                        n_mode  = MODE_IDLE;
                        w_event = EV_DONE;
                    end else begin
                        n_secs = r_secs - SECS_W'(1);
                    end
                end else if (r_in.op == OP_STOP) begin
                    n_mode  = MODE_PAUSE;
                    w_event = EV_OK;
                end
            end
            MODE_PAUSE: begin
                if (r_in.op == OP_START) begin
                    n_mode  = MODE_RUN;
                    w_event = EV_OK;
                end else if (r_in.op == OP_STOP) begin
                    n_mode  = MODE_IDLE;
                    n_secs  = '0;
                    w_event = EV_STOPPED;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase
    end

    // Result item built from the next state.
    always_comb begin
        w_res.mode              = n_mode;
        w_res.remaining_seconds = (n_mode == MODE_RUN || n_mode == MODE_PAUSE)
                                ? n_secs : '0;
        w_res.entered_digits    = {n_digit[0], n_digit[1], n_digit[2], n_digit[3]};
        w_res.lamp_on           = (n_mode == MODE_RUN);
        w_res.event_res         = w_event;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preset  <= PRESET_RESET;
            r_beef    <= BEEF_RESET;
            r_chicken <= CHICKEN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PRESET:  r_preset  <= i_cfg_data;
                CFG_BEEF:    r_beef    <= i_cfg_data[RATE_W-1:0];
                CFG_CHICKEN: r_chicken <= i_cfg_data[RATE_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_chick <= 1'b0;
            r_digit <= '{default: '0};
            r_count <= '0;
            r_secs  <= '0;
        end else if (w_fire) begin
            r_mode  <= n_mode;
            r_chick <= n_chick;
            r_digit <= n_digit;
            r_count <= n_count;
            r_secs  <= n_secs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_vld <= 1'b1;
            end else if (w_fire) begin
                r_in_vld <= 1'b0;
            end
            if (w_fire) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_fire) begin
            r_out <= w_res;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/ctec_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cook timer entry controller checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ctec_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire ctec_pkg::t_out_item o_out_data
);
    import ctec_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("Result changed or dropped while stalled.");

    a_lamp_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.lamp_on == (o_out_data.mode == MODE_RUN)))
        else $error("Lamp state disagrees with the running mode.");

    a_secs_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.mode != MODE_RUN && o_out_data.mode != MODE_PAUSE)
            |-> (o_out_data.remaining_seconds == '0))
        else $error("Remaining time shown outside a run.");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.event_res == EV_DONE
                         || o_out_data.event_res == EV_STOPPED))
            |-> (o_out_data.mode == MODE_IDLE))
        else $error("Run ended without returning to idle.");

    a_run_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.mode == MODE_RUN)
            |-> (o_out_data.remaining_seconds != '0))
        else $error("Running with no time left.");

endmodule

bind cook_timer_entry_controller_top ctec_checker u_ctec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire
